/* src/afc_pkg.sv */
package afc_pkg;

    localparam int unsigned PERIOD_W    = 17;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned RATE_W      = 9;
    localparam int unsigned PLAYED_W    = 16;
    localparam int unsigned LENGTH_W    = 12;
    localparam int unsigned RATE_IDX_W  = 4;

    localparam logic [PERIOD_W-1:0] FOUR_STEP_PERIOD_RST = 17'd89490;
    localparam logic [PERIOD_W-1:0] FIVE_STEP_PERIOD_RST = 17'd111860;

    localparam logic [ADDR_W-1:0] ADDR_FRAME_CTRL  = 16'h4017;
    localparam logic [ADDR_W-1:0] ADDR_SAMPLE_CTRL = 16'h4010;
    localparam logic [ADDR_W-1:0] ADDR_SAMPLE_LEN  = 16'h4013;
    localparam logic [ADDR_W-1:0] ADDR_STATUS      = 16'h4015;

    localparam int unsigned BIT_MODE        = 7;
    localparam int unsigned BIT_IRQ_INHIBIT = 6;
    localparam int unsigned BIT_IRQ_ENABLE  = 7;
    localparam int unsigned BIT_LOOP        = 6;
    localparam int unsigned BIT_SAMPLE_EN   = 4;

    localparam logic CFG_FOUR_STEP_PERIOD = 1'b0;
    localparam logic CFG_FIVE_STEP_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE     = 2'd0,
        ACT_TICK      = 2'd1,
        ACT_RD_FRAME  = 2'd2,
        ACT_RD_SAMPLE = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   data;
    } item_t;

    function automatic logic [RATE_W-1:0] rate_lookup(input logic [RATE_IDX_W-1:0] idx);
        logic [RATE_W-1:0] r;
        case (idx)
            4'd0:    r = 9'd428;
            4'd1:    r = 9'd380;
            4'd2:    r = 9'd340;
            4'd3:    r = 9'd320;
            4'd4:    r = 9'd286;
            4'd5:    r = 9'd254;
            4'd6:    r = 9'd226;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd190;
            4'd9:    r = 9'd160;
            4'd10:   r = 9'd142;
            4'd11:   r = 9'd128;
            4'd12:   r = 9'd106;
            4'd13:   r = 9'd84;
            4'd14:   r = 9'd72;
            4'd15:   r = 9'd54;
            default: r = 9'd428;
        endcase
        return r;
    endfunction

endpackage

/* src/afc_frame_seq.sv */
module afc_frame_seq
    import afc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  item_t               item,
    input  logic [PERIOD_W-1:0] four_step_period,
    input  logic [PERIOD_W-1:0] five_step_period,
    output logic                irq_flag,
    output logic                irq_flag_next
);

    logic                five_step_mode_reg,   five_step_mode_next;
    logic [PERIOD_W-1:0] frame_countdown_reg,  frame_countdown_next;
    logic [1:0]          frame_step_reg,       frame_step_next;
    logic                frame_irq_enable_reg, frame_irq_enable_next;
    logic                frame_irq_flag_reg,   frame_irq_flag_next;

    logic [PERIOD_W-1:0] count_dec;
    logic [PERIOD_W-1:0] period_cur;
    logic                mode_wr;

    assign count_dec  = frame_countdown_reg - 1'b1;
    assign period_cur = five_step_mode_reg ? five_step_period : four_step_period;
    assign mode_wr    = item.data[BIT_MODE];

    always_comb
    begin
        five_step_mode_next   = five_step_mode_reg;
        frame_countdown_next  = frame_countdown_reg;
        frame_step_next       = frame_step_reg;
        frame_irq_enable_next = frame_irq_enable_reg;
        frame_irq_flag_next   = frame_irq_flag_reg;
        case (item.action)
            ACT_WRITE:
            begin
                if (item.address == ADDR_FRAME_CTRL)
                begin
                    five_step_mode_next   = mode_wr;
                    frame_countdown_next  = mode_wr ? five_step_period : four_step_period;
                    frame_irq_enable_next = !item.data[BIT_IRQ_INHIBIT];
                end
            end
            ACT_TICK:
            begin
                frame_countdown_next = count_dec;
                if (count_dec == '0)
                begin
                    frame_countdown_next = period_cur;
                    if (!five_step_mode_reg)
                    begin
                        if (frame_step_reg == 2'd3 && frame_irq_enable_reg)
                            frame_irq_flag_next = 1'b1;
                        frame_step_next = frame_step_reg + 2'd1;
                    end
                end
            end
            ACT_RD_FRAME:
            begin
                frame_irq_flag_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            five_step_mode_reg   <= 1'b0;
            frame_countdown_reg  <= FOUR_STEP_PERIOD_RST;
            frame_step_reg       <= 2'd0;
            frame_irq_enable_reg <= 1'b0;
            frame_irq_flag_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            five_step_mode_reg   <= five_step_mode_next;
            frame_countdown_reg  <= frame_countdown_next;
            frame_step_reg       <= frame_step_next;
            frame_irq_enable_reg <= frame_irq_enable_next;
            frame_irq_flag_reg   <= frame_irq_flag_next;
        end
    end

    assign irq_flag      = frame_irq_flag_reg;
    assign irq_flag_next = frame_irq_flag_next;

endmodule

/* src/afc_sample_timer.sv */
module afc_sample_timer
    import afc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step_en,
    input  item_t item,
    output logic  irq_flag,
    output logic  irq_flag_next
);

    logic                  sample_enable_reg,     sample_enable_next;
    logic                  sample_irq_enable_reg, sample_irq_enable_next;
    logic                  sample_loop_reg,       sample_loop_next;
    logic [RATE_IDX_W-1:0] rate_index_reg,        rate_index_next;
    logic [LENGTH_W-1:0]   sample_length_reg,     sample_length_next;
    logic [1:0]            tick_phase_reg,        tick_phase_next;
    logic [RATE_W-1:0]     rate_count_reg,        rate_count_next;
    logic [PLAYED_W-1:0]   played_count_reg,      played_count_next;
    logic                  sample_irq_flag_reg,   sample_irq_flag_next;

    logic [RATE_W-1:0]     rate_inc;
    logic [PLAYED_W-1:0]   played_inc;

    assign rate_inc   = rate_count_reg + 1'b1;
    assign played_inc = played_count_reg + 1'b1;

    always_comb
    begin
        sample_enable_next     = sample_enable_reg;
        sample_irq_enable_next = sample_irq_enable_reg;
        sample_loop_next       = sample_loop_reg;
        rate_index_next        = rate_index_reg;
        sample_length_next     = sample_length_reg;
        tick_phase_next        = tick_phase_reg;
        rate_count_next        = rate_count_reg;
        played_count_next      = played_count_reg;
        sample_irq_flag_next   = sample_irq_flag_reg;
        case (item.action)
            ACT_WRITE:
            begin
                if (item.address == ADDR_SAMPLE_CTRL)
                begin
                    sample_irq_enable_next = item.data[BIT_IRQ_ENABLE];
                    sample_loop_next       = item.data[BIT_LOOP];
                    rate_index_next        = item.data[RATE_IDX_W-1:0];
                end
                else if (item.address == ADDR_SAMPLE_LEN)
                begin
                    sample_length_next = {item.data, 4'b0001};
                end
                else if (item.address == ADDR_STATUS)
                begin
                    sample_enable_next = item.data[BIT_SAMPLE_EN];
                end
            end
            ACT_TICK:
            begin
                if (sample_enable_reg)
                begin
                    if (tick_phase_reg == 2'd0 || tick_phase_reg == 2'd3)
                    begin
                        rate_count_next = rate_inc;
                        if (rate_inc == rate_lookup(rate_index_reg))
                        begin
                            rate_count_next   = '0;
                            played_count_next = played_inc;
                            if (played_inc == PLAYED_W'(sample_length_reg)
                                && !sample_loop_reg && sample_irq_enable_reg)
                            begin
                                sample_irq_flag_next = 1'b1;
                                played_count_next    = '0;
                            end
                        end
                    end
                    tick_phase_next = tick_phase_reg + 2'd1;
                end
            end
            ACT_RD_SAMPLE:
            begin
                sample_irq_flag_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_enable_reg     <= 1'b0;
            sample_irq_enable_reg <= 1'b0;
            sample_loop_reg       <= 1'b0;
            rate_index_reg        <= '0;
            sample_length_reg     <= '0;
            tick_phase_reg        <= 2'd0;
            rate_count_reg        <= '0;
            played_count_reg      <= '0;
            sample_irq_flag_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            sample_enable_reg     <= sample_enable_next;
            sample_irq_enable_reg <= sample_irq_enable_next;
            sample_loop_reg       <= sample_loop_next;
            rate_index_reg        <= rate_index_next;
            sample_length_reg     <= sample_length_next;
            tick_phase_reg        <= tick_phase_next;
            rate_count_reg        <= rate_count_next;
            played_count_reg      <= played_count_next;
            sample_irq_flag_reg   <= sample_irq_flag_next;
        end
    end

    assign irq_flag      = sample_irq_flag_reg;
    assign irq_flag_next = sample_irq_flag_next;

endmodule

/* src/apu_frame_counter_and_dmc_timer_unit.sv */
// Frame sequencer and sample-rate timer. Each input beat (bus write, clock tick or
// read-clear of one irq flag) produces exactly one output beat with the flag that
// was read and both irq flags after the beat. The block takes one beat per cycle while
// the output is not stalled: a beat is captured in an input register, all state is
// updated by a single pass of counter logic as the beat leaves that register, and the
// result lands in an output register. When the output is stalled one more beat is held
// in the input register before s_tready drops. Period registers are written through
// cfg_wen/cfg_index/cfg_wdata and take effect at the next reload or mode write.
module apu_frame_counter_and_dmc_timer_unit
    import afc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]          s_tuser,   // action[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // flag_was_set[0], frame_irq_pending[1],
                                           // sample_irq_pending[2], zero[7:3]
    input  logic                cfg_wen,
    input  logic                cfg_index,
    input  logic [PERIOD_W-1:0] cfg_wdata
);

    logic [PERIOD_W-1:0] four_step_period_reg;
    logic [PERIOD_W-1:0] five_step_period_reg;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic [2:0]  out_data_reg, out_data_next;

    logic        out_free;
    logic        advance;
    logic        frame_flag, frame_flag_next;
    logic        sample_flag, sample_flag_next;
    logic        was_set;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_step_period_reg <= FOUR_STEP_PERIOD_RST;
            five_step_period_reg <= FIVE_STEP_PERIOD_RST;
        end
        else if (cfg_wen)
        begin
            if (cfg_index == CFG_FOUR_STEP_PERIOD)
                four_step_period_reg <= cfg_wdata;
            else
                five_step_period_reg <= cfg_wdata;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.action  <= action_t'(s_tuser);
            in_item_reg.address <= s_tdata[15:0];
            in_item_reg.data    <= s_tdata[23:16];
        end
    end

    afc_frame_seq u_frame_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (advance),
        .item             (in_item_reg),
        .four_step_period (four_step_period_reg),
        .five_step_period (five_step_period_reg),
        .irq_flag         (frame_flag),
        .irq_flag_next    (frame_flag_next)
    );

    afc_sample_timer u_sample_timer (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .item          (in_item_reg),
        .irq_flag      (sample_flag),
        .irq_flag_next (sample_flag_next)
    );

    always_comb
    begin
        case (in_item_reg.action)
            ACT_RD_FRAME:  was_set = frame_flag;
            ACT_RD_SAMPLE: was_set = sample_flag;
            default:       was_set = 1'b0;
        endcase
        out_data_next = {sample_flag_next, frame_flag_next, was_set};
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg};

    a_rd_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.action == ACT_RD_FRAME |=> !m_tdata[1])
        else $error("frame irq still pending after read-clear");

    a_rd_sample_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.action == ACT_RD_SAMPLE |=> !m_tdata[2])
        else $error("sample irq still pending after read-clear");

    a_was_set_only_reads: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.action == ACT_WRITE || in_item_reg.action == ACT_TICK)
        |=> !m_tdata[0])
        else $error("flag_was_set on a write or tick beat");

    a_no_advance_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !advance)
        else $error("state advanced while result stalled");

endmodule

/* tb/tb_apu_frame_counter_and_dmc_timer_unit.sv */
module tb_apu_frame_counter_and_dmc_timer_unit;
    import afc_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASES       = 6;
    localparam int RANDOM_BEATS = 245;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata   = '0;   // address[15:0], data[23:16]
    logic [1:0]          s_tuser   = '0;   // action[1:0]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;          // flag_was_set[0], frame_irq_pending[1],
                                           // sample_irq_pending[2], zero[7:3]
    logic                cfg_wen   = 1'b0;
    logic                cfg_index = 1'b0;
    logic [PERIOD_W-1:0] cfg_wdata = '0;

    apu_frame_counter_and_dmc_timer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predicted block state
    logic [PERIOD_W-1:0]   four_period    = FOUR_STEP_PERIOD_RST;
    logic [PERIOD_W-1:0]   five_period    = FIVE_STEP_PERIOD_RST;
    logic                  five_mode      = 1'b0;
    logic [PERIOD_W-1:0]   frame_count    = FOUR_STEP_PERIOD_RST;
    logic [1:0]            frame_phase    = 2'd0;
    logic                  frame_irq_en   = 1'b0;
    logic                  frame_irq      = 1'b0;
    logic                  dmc_en         = 1'b0;
    logic                  dmc_irq_en     = 1'b0;
    logic                  dmc_loop       = 1'b0;
    logic [RATE_IDX_W-1:0] rate_sel       = '0;
    logic [LENGTH_W-1:0]   dmc_length     = '0;
    logic [1:0]            tick_phase     = 2'd0;
    logic [RATE_W-1:0]     rate_count     = '0;
    logic [PLAYED_W-1:0]   played         = '0;
    logic                  dmc_irq        = 1'b0;

    logic [RATE_W-1:0] dmc_rates [16] = '{
        9'd428, 9'd380, 9'd340, 9'd320, 9'd286, 9'd254, 9'd226, 9'd214,
        9'd190, 9'd160, 9'd142, 9'd128, 9'd106, 9'd84,  9'd72,  9'd54
    };

    item_t      pending_beats [$];
    logic [2:0] expected_flags [$];
    item_t      next_beat;
    logic [2:0] next_flags;
    logic [2:0] want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int beats_done    = 0;
    int frame_hits    = 0;
    int sample_hits   = 0;
    int quiet_cycles  = 0;

    // returns {sample_irq, frame_irq, flag_was_set} after one beat
    function automatic logic [2:0] predict_flags(action_t act, logic [ADDR_W-1:0] addr,
                                                 logic [DATA_W-1:0] dat);
        logic was;
        was = 1'b0;
        case (act)
            ACT_WRITE:
            begin
                case (addr)
                    ADDR_FRAME_CTRL:
                    begin
                        five_mode    = dat[BIT_MODE];
                        frame_count  = five_mode ? five_period : four_period;
                        frame_irq_en = !dat[BIT_IRQ_INHIBIT];
                    end
                    ADDR_SAMPLE_CTRL:
                    begin
                        dmc_irq_en = dat[BIT_IRQ_ENABLE];
                        dmc_loop   = dat[BIT_LOOP];
                        rate_sel   = dat[3:0];
                    end
                    ADDR_SAMPLE_LEN:
                        dmc_length = {dat, 4'h1};
                    ADDR_STATUS:
                        dmc_en = dat[BIT_SAMPLE_EN];
                    default:
                        ;
                endcase
            end
            ACT_TICK:
            begin
                frame_count = frame_count - 1'b1;
                if (frame_count == '0)
                begin
                    frame_count = five_mode ? five_period : four_period;
                    if (!five_mode)
                    begin
                        if (frame_phase == 2'd3 && frame_irq_en)
                            frame_irq = 1'b1;
                        frame_phase = frame_phase + 1'b1;
                    end
                end
                if (dmc_en)
                begin
                    if (tick_phase == 2'd0 || tick_phase == 2'd3)
                    begin
                        rate_count = rate_count + 1'b1;
                        if (rate_count == dmc_rates[rate_sel])
                        begin
                            rate_count = '0;
                            played     = played + 1'b1;
                            if (played == PLAYED_W'(dmc_length) && !dmc_loop && dmc_irq_en)
                            begin
                                dmc_irq = 1'b1;
                                played  = '0;
                            end
                        end
                    end
                    tick_phase = tick_phase + 1'b1;
                end
            end
            ACT_RD_FRAME:
            begin
                was       = frame_irq;
                frame_irq = 1'b0;
            end
            default:
            begin
                was     = dmc_irq;
                dmc_irq = 1'b0;
            end
        endcase
        return {dmc_irq, frame_irq, was};
    endfunction

    task automatic add_beat(action_t act, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] dat);
        item_t b;
        b.action  = act;
        b.address = addr;
        b.data    = dat;
        pending_beats.push_back(b);
    endtask

    // mostly ticks and well-formed register writes, some reads and stray writes
    task automatic add_random_beat();
        int                r;
        int                pick;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] dat;
        action_t           act;
        r    = $urandom_range(99);
        addr = ADDR_W'($urandom);
        dat  = DATA_W'($urandom);
        act  = ACT_WRITE;
        if (r < 72)
            act = ACT_TICK;
        else if (r < 77)
            act = ACT_RD_FRAME;
        else if (r < 82)
            act = ACT_RD_SAMPLE;
        else if (r < 92)
        begin
            pick = $urandom_range(9);
            if (pick < 2)
            begin
                addr = ADDR_FRAME_CTRL;
                if ($urandom_range(3) != 0)
                    dat[7:6] = 2'b00;
            end
            else if (pick < 4)
            begin
                addr = ADDR_SAMPLE_CTRL;
                if ($urandom_range(3) != 0)
                begin
                    dat[BIT_IRQ_ENABLE] = 1'b1;
                    dat[BIT_LOOP]       = 1'b0;
                    dat[3:2]            = 2'b11;
                end
            end
            else if (pick < 6)
            begin
                addr = ADDR_SAMPLE_LEN;
                if ($urandom_range(1) != 0)
                    dat = '0;
            end
            else
            begin
                addr = ADDR_STATUS;
                if ($urandom_range(3) != 0)
                    dat[BIT_SAMPLE_EN] = 1'b1;
            end
        end
        add_beat(act, addr, dat);
    endtask

    task automatic write_period(logic idx, logic [PERIOD_W-1:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_FOUR_STEP_PERIOD)
            four_period = val;
        else
            five_period = val;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (pending_beats.size() != 0 || s_tvalid || expected_flags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                next_flags = predict_flags(action_t'(s_tuser), s_tdata[15:0], s_tdata[23:16]);
                expected_flags.push_back(next_flags);
                beats_done++;
                if (next_flags[0])
                begin
                    if (s_tuser == ACT_RD_FRAME)
                        frame_hits++;
                    else
                        sample_hits++;
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_beat.data, next_beat.address};
                    s_tuser  <= next_beat.action;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_flags.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %b", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_flags.pop_front();
                if (m_tdata !== {5'b0, want})
                begin
                    $display("%0t: result mismatch, expected %b, got %b",
                             $time, {5'b0, want}, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [PERIOD_W-1:0] p4;
        logic [PERIOD_W-1:0] p5;
        int                  ph;
        int                  k;

        send_idle_pct = 22;
        recv_idle_pct = 69;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset periods, nothing enabled, stray addresses
        add_beat(ACT_RD_FRAME, 16'h0000, 8'h00);
        add_beat(ACT_RD_SAMPLE, 16'hFFFF, 8'hFF);
        add_beat(ACT_TICK, 16'hFFFF, 8'hFF);
        add_beat(ACT_WRITE, 16'h4016, 8'hFF);
        add_beat(ACT_WRITE, 16'h4011, 8'hFF);
        add_beat(ACT_WRITE, 16'h0000, 8'h00);

        for (ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 69 : 0;
            recv_idle_pct = (ph < 2) ? 69 : (ph < 4) ? 22 : 0;
            drain_and_settle();
            case (ph)
                0:       begin p4 = 17'd1;      p5 = 17'd131071; end
                1:       begin p4 = 17'd3;      p5 = 17'd2;      end
                2:       begin p4 = 17'd0;      p5 = 17'd7;      end
                3:       begin p4 = 17'd131071; p5 = 17'd1;      end
                default: begin
                    p4 = PERIOD_W'($urandom_range(40, 1));
                    p5 = PERIOD_W'($urandom_range(40, 1));
                end
            endcase
            write_period(CFG_FOUR_STEP_PERIOD, p4);
            write_period(CFG_FIVE_STEP_PERIOD, p5);

            if (ph == 0)
            begin
                // fastest rate, length one, frame irq after four ticks
                add_beat(ACT_WRITE, ADDR_SAMPLE_CTRL, 8'h8F);
                add_beat(ACT_WRITE, ADDR_SAMPLE_LEN, 8'h00);
                add_beat(ACT_WRITE, ADDR_STATUS, 8'h10);
                add_beat(ACT_WRITE, ADDR_FRAME_CTRL, 8'h00);
                for (k = 0; k < 4; k++)
                    add_beat(ACT_TICK, 16'h0000, 8'h00);
                add_beat(ACT_RD_FRAME, 16'h0000, 8'h00);
                add_beat(ACT_RD_FRAME, 16'h0000, 8'h00);
                add_beat(ACT_RD_SAMPLE, 16'h0000, 8'h00);
                add_beat(ACT_WRITE, ADDR_FRAME_CTRL, 8'h80);
                add_beat(ACT_TICK, 16'h0000, 8'h00);
                add_beat(ACT_WRITE, ADDR_FRAME_CTRL, 8'hC0);
                add_beat(ACT_WRITE, ADDR_FRAME_CTRL, 8'h40);
                add_beat(ACT_WRITE, ADDR_SAMPLE_LEN, 8'hFF);
                add_beat(ACT_WRITE, ADDR_SAMPLE_CTRL, 8'h4F);
                add_beat(ACT_WRITE, ADDR_SAMPLE_CTRL, 8'hCF);
                add_beat(ACT_WRITE, ADDR_STATUS, 8'hEF);
                add_beat(ACT_WRITE, ADDR_STATUS, 8'h10);
                add_beat(ACT_WRITE, ADDR_SAMPLE_CTRL, 8'h80);
                add_beat(ACT_WRITE, 16'hFFFF, 8'hFF);
            end

            // bring the timers into a running state, then random traffic
            add_beat(ACT_WRITE, ADDR_SAMPLE_CTRL, {2'b10, 2'b00, 2'b11, 2'($urandom)});
            add_beat(ACT_WRITE, ADDR_SAMPLE_LEN, DATA_W'($urandom_range(2)));
            add_beat(ACT_WRITE, ADDR_STATUS, DATA_W'($urandom) | 8'h10);
            add_beat(ACT_WRITE, ADDR_FRAME_CTRL, {2'b00, 6'($urandom)});
            for (k = 0; k < RANDOM_BEATS; k++)
                add_random_beat();
        end

        drain_and_settle();
        repeat (8) @(posedge clk);

        $display("covered %0d beats over %0d period settings and three idle profiles", beats_done,
                 PHASES + 1);
        $display("frame irq read back set %0d times, sample irq %0d times, %0d mismatches",
                 frame_hits, sample_hits, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* apu_frame_counter_and_dmc_timer_unit.f */
src/afc_pkg.sv
src/afc_frame_seq.sv
src/afc_sample_timer.sv
src/apu_frame_counter_and_dmc_timer_unit.sv
tb/tb_apu_frame_counter_and_dmc_timer_unit.sv
